>>> rtl/line_clip_color_interp_top_defines.svh
// Assertion macros for the line clipper.
`ifndef LINE_CLIP_COLOR_INTERP_TOP_DEFINES_SVH
`define LINE_CLIP_COLOR_INTERP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LCCI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LCCI_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define LCCI_ASSERT(lbl, prop, msg)
`define LCCI_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/lcci_pkg.sv
package lcci_pkg;

	localparam int DivSteps = 16;
	localparam logic [16:0] UOne = 17'h10000;
	localparam logic [16:0] UOver = 17'h10001;

	typedef enum logic [1:0] {
		EDGE_SKIP,
		EDGE_REJECT,
		EDGE_ENTER,
		EDGE_LEAVE
	} edge_kind_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] den;
		logic [15:0] quo;
		edge_kind_t kind;
		logic ovf;
		logic eq;
	} lane_t;

	typedef lane_t [3:0] lanes_t;

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic [2:0][7:0] c0;
		logic [2:0][7:0] c1;
	} seg_t;

	typedef struct packed {
		logic vis;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
		logic [2:0][7:0] cs;
		logic [2:0][7:0] ce;
	} res_t;

	function automatic lane_t make_lane(input logic signed [16:0] p,
			input logic signed [16:0] q);
		lane_t l;
		logic [16:0] n;
		logic [16:0] d;
		l = '0;
		n = '0;
		d = '0;
		l.kind = EDGE_SKIP;
		if (p == 17'sd0) begin
			l.kind = (q < 17'sd0) ? EDGE_REJECT : EDGE_SKIP;
		end else if (p < 17'sd0) begin
			if (q <= 17'sd0) begin
				l.kind = EDGE_ENTER;
				n = 17'(-q);
				d = 17'(-p);
			end
		end else begin
			if (q < 17'sd0) begin
				l.kind = EDGE_REJECT;
			end else begin
				l.kind = EDGE_LEAVE;
				n = 17'(q);
				d = 17'(p);
			end
		end
		l.ovf = (n >= d);
		l.eq = (n == d);
		l.den = d[15:0];
		l.rem = l.ovf ? 16'd0 : n[15:0];
		return l;
	endfunction

	function automatic logic [16:0] lane_ratio(input lane_t l);
		if (l.ovf) begin
			return l.eq ? UOne : UOver;
		end
		return {1'b0, l.quo};
	endfunction

endpackage

>>> rtl/lcci_div_cell.sv
module lcci_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  lcci_pkg::lanes_t in_lanes,
	input  lcci_pkg::seg_t   in_seg,
	output logic             out_valid,
	output lcci_pkg::lanes_t out_lanes,
	output lcci_pkg::seg_t   out_seg
);

	logic valid_q;
	lcci_pkg::lanes_t lanes_q;
	lcci_pkg::lanes_t lanes_d;
	lcci_pkg::seg_t seg_q;

	always_comb begin
		logic [16:0] sh;
		logic ge;
		lanes_d = in_lanes;
		for (int i = 0; i < 4; i++) begin
			sh = {in_lanes[i].rem, 1'b0};
			ge = (sh >= {1'b0, in_lanes[i].den});
			lanes_d[i].rem = ge ? 16'(sh - {1'b0, in_lanes[i].den}) : sh[15:0];
			lanes_d[i].quo = {in_lanes[i].quo[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= lanes_d;
			seg_q <= in_seg;
		end
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;
	assign out_seg = seg_q;

endmodule

>>> rtl/lcci_lerp.sv
module lcci_lerp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  lcci_pkg::lanes_t lanes,
	input  lcci_pkg::seg_t   seg,
	output logic             out_valid,
	output lcci_pkg::res_t   res
);

	logic valid_s1, valid_s2, valid_s3;
	logic vis_s1, vis_s2;
	logic [16:0] u1_s1, u2_s1;
	lcci_pkg::seg_t seg_s1;
	logic [16:0] u1_c, u2_c;
	logic vis_c;

	logic signed [34:0] px1_s2, py1_s2, px2_s2, py2_s2;
	logic signed [26:0] pc1_s2 [3];
	logic signed [26:0] pc2_s2 [3];
	logic signed [15:0] x1_s2, y1_s2;
	logic [2:0][7:0] c0_s2;
	lcci_pkg::res_t res_s3;
	lcci_pkg::res_t res_c;

	always_comb begin
		logic [16:0] r;
		u1_c = '0;
		u2_c = lcci_pkg::UOne;
		vis_c = 1'b1;
		for (int i = 0; i < 4; i++) begin
			r = lcci_pkg::lane_ratio(lanes[i]);
			if (vis_c) begin
				case (lanes[i].kind)
					lcci_pkg::EDGE_REJECT: begin
						vis_c = 1'b0;
					end
					lcci_pkg::EDGE_ENTER: begin
						if (r > u2_c) vis_c = 1'b0;
						else if (r > u1_c) u1_c = r;
					end
					lcci_pkg::EDGE_LEAVE: begin
						if (r < u1_c) vis_c = 1'b0;
						else if (r < u2_c) u2_c = r;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1 <= vis_c;
			u1_s1 <= u1_c;
			u2_s1 <= u2_c;
			seg_s1 <= seg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s2 <= vis_s1;
			x1_s2 <= seg_s1.x1;
			y1_s2 <= seg_s1.y1;
			c0_s2 <= seg_s1.c0;
			px1_s2 <= 35'($signed({1'b0, u1_s1}) * seg_s1.dx);
			py1_s2 <= 35'($signed({1'b0, u1_s1}) * seg_s1.dy);
			px2_s2 <= 35'($signed({1'b0, u2_s1}) * seg_s1.dx);
			py2_s2 <= 35'($signed({1'b0, u2_s1}) * seg_s1.dy);
			for (int i = 0; i < 3; i++) begin
				pc1_s2[i] <= 27'($signed({1'b0, u1_s1}) *
					$signed(9'({1'b0, seg_s1.c1[i]}) - 9'({1'b0, seg_s1.c0[i]})));
				pc2_s2[i] <= 27'($signed({1'b0, u2_s1}) *
					$signed(9'({1'b0, seg_s1.c1[i]}) - 9'({1'b0, seg_s1.c0[i]})));
			end
		end
	end

	always_comb begin
		logic signed [34:0] t;
		logic [26:0] v;
		t = '0;
		v = '0;
		res_c = '0;
		if (vis_s2) begin
			res_c.vis = 1'b1;
			t = px1_s2 + 35'sd32768;
			res_c.sx = 16'(x1_s2 + $signed(t[31:16]));
			t = py1_s2 + 35'sd32768;
			res_c.sy = 16'(y1_s2 + $signed(t[31:16]));
			t = px2_s2 + 35'sd32768;
			res_c.ex = 16'(x1_s2 + $signed(t[31:16]));
			t = py2_s2 + 35'sd32768;
			res_c.ey = 16'(y1_s2 + $signed(t[31:16]));
			for (int i = 0; i < 3; i++) begin
				v = 27'({3'b000, c0_s2[i], 16'h0000}) + 27'(pc1_s2[i]);
				res_c.cs[i] = v[23:16];
				v = 27'({3'b000, c0_s2[i], 16'h0000}) + 27'(pc2_s2[i]);
				res_c.ce[i] = v[23:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_c;
		end
	end

	assign out_valid = valid_s3;
	assign res = res_s3;

endmodule

>>> rtl/line_clip_color_interp_top.sv
// Channel  Direction  Handshake              Payload
// in       into       in_valid / in_stall    segment ends and end colors
// out      out of     out_valid / out_stall  visible flag, clipped ends, colors
// cfg      into       cfg_write              cfg_index, cfg_data (window edges)
//
// One segment enters per cycle while in_stall is low; each result passes
// through the chain of 16 divider cells, one quotient bit each, followed
// by the edge-combine, multiply and output stages.
// Reset clears all valid flags and loads the default window.
// A stalled result freezes the whole pipeline and holds in_stall high.
`include "line_clip_color_interp_top_defines.svh"
module line_clip_color_interp_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [7:0]         start_red,
	input  logic [7:0]         start_green,
	input  logic [7:0]         start_blue,
	input  logic [7:0]         end_red,
	input  logic [7:0]         end_green,
	input  logic [7:0]         end_blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible,
	output logic signed [15:0] clip_start_x,
	output logic signed [15:0] clip_start_y,
	output logic signed [15:0] clip_end_x,
	output logic signed [15:0] clip_end_y,
	output logic [7:0]         clip_start_red,
	output logic [7:0]         clip_start_green,
	output logic [7:0]         clip_start_blue,
	output logic [7:0]         clip_end_red,
	output logic [7:0]         clip_end_green,
	output logic [7:0]         clip_end_blue
);

	localparam logic [1:0] RegMinX = 2'd0;
	localparam logic [1:0] RegMinY = 2'd1;
	localparam logic [1:0] RegMaxX = 2'd2;
	localparam logic [1:0] RegMaxY = 2'd3;

	logic signed [15:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic en;
	logic signed [16:0] dx, dy, x1e, y1e;
	logic v_c [lcci_pkg::DivSteps + 1];
	lcci_pkg::lanes_t lanes_c [lcci_pkg::DivSteps + 1];
	lcci_pkg::seg_t seg_c [lcci_pkg::DivSteps + 1];
	lcci_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= 16'sd0;
			min_y_q <= 16'sd0;
			max_x_q <= 16'sd10224;
			max_y_q <= 16'sd7664;
		end else if (cfg_write) begin
			case (cfg_index)
				RegMinX: min_x_q <= cfg_data;
				RegMinY: min_y_q <= cfg_data;
				RegMaxX: max_x_q <= cfg_data;
				RegMaxY: max_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	assign x1e = 17'(start_x);
	assign y1e = 17'(start_y);
	assign dx = 17'(end_x) - x1e;
	assign dy = 17'(end_y) - y1e;

	always_comb begin
		v_c[0] = in_valid;
		lanes_c[0][0] = lcci_pkg::make_lane(-dx, x1e - 17'(min_x_q));
		lanes_c[0][1] = lcci_pkg::make_lane(dx, 17'(max_x_q) - x1e);
		lanes_c[0][2] = lcci_pkg::make_lane(-dy, y1e - 17'(min_y_q));
		lanes_c[0][3] = lcci_pkg::make_lane(dy, 17'(max_y_q) - y1e);
		seg_c[0].x1 = start_x;
		seg_c[0].y1 = start_y;
		seg_c[0].dx = dx;
		seg_c[0].dy = dy;
		seg_c[0].c0 = {start_blue, start_green, start_red};
		seg_c[0].c1 = {end_blue, end_green, end_red};
	end

	for (genvar g = 0; g < lcci_pkg::DivSteps; g++) begin : g_cell
		lcci_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[g]),
			.in_lanes  (lanes_c[g]),
			.in_seg    (seg_c[g]),
			.out_valid (v_c[g + 1]),
			.out_lanes (lanes_c[g + 1]),
			.out_seg   (seg_c[g + 1])
		);
	end

	lcci_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_c[lcci_pkg::DivSteps]),
		.lanes     (lanes_c[lcci_pkg::DivSteps]),
		.seg       (seg_c[lcci_pkg::DivSteps]),
		.out_valid (out_valid),
		.res       (res)
	);

	assign visible = res.vis;
	assign clip_start_x = res.sx;
	assign clip_start_y = res.sy;
	assign clip_end_x = res.ex;
	assign clip_end_y = res.ey;
	assign clip_start_red = res.cs[0];
	assign clip_start_green = res.cs[1];
	assign clip_start_blue = res.cs[2];
	assign clip_end_red = res.ce[0];
	assign clip_end_green = res.ce[1];
	assign clip_end_blue = res.ce[2];

	`LCCI_ASSERT(a_stall_only_on_wait, in_stall |-> out_valid, "stall without a waiting result")
	`LCCI_ASSERT(a_reject_zero, (out_valid && !visible) |-> (clip_start_x == 16'sd0 && clip_end_x == 16'sd0 && clip_start_red == 8'd0 && clip_end_blue == 8'd0), "rejected result not zero")
	`LCCI_NEVER(a_bad_window_index, cfg_write && $isunknown(cfg_index), "unknown register index")

endmodule
